### sv/fmfd_pkg.sv
// ----------------------------------------------------------------------------
// fmfd_pkg
// Shared types, constants and modular add/subtract helpers for the
// Fibonacci fast-doubling block.
// ----------------------------------------------------------------------------
package fmfd_pkg;

    // Modulus and residue width.
    localparam int MOD_WIDTH = 63;

    // Default number of index bits walked.
    localparam int INDEX_WIDTH_DEF = 64;

    // One multiplier step per multiplier bit; operands are below p < 2^63.
    localparam int MUL_STEPS = MOD_WIDTH;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    typedef logic [MOD_WIDTH-1:0] res_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DBL,
        ST_SUB,
        ST_MUL_C,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_UPD,
        ST_FIN
    } state_t;

    // (x + y) mod p for x, y < p; the sum needs one extra bit.
    function automatic res_t add_mod(input res_t x, input res_t y, input res_t p);
        logic [MOD_WIDTH:0] s;
        logic [MOD_WIDTH:0] r;
        s = {1'b0, x} + {1'b0, y};
        r = (s >= {1'b0, p}) ? (s - {1'b0, p}) : s;
        return r[MOD_WIDTH-1:0];
    endfunction

    // (x - y) mod p for x, y < p.
    function automatic res_t sub_mod(input res_t x, input res_t y, input res_t p);
        res_t r;
        r = (x >= y) ? (x - y) : (x + (p - y));
        return r;
    endfunction

endpackage

### sv/fmfd_if.sv
// ----------------------------------------------------------------------------
// fmfd_req_if / fmfd_rsp_if
// Valid/ready channels carrying Fibonacci requests and residues.
// ----------------------------------------------------------------------------
interface fmfd_req_if
    import fmfd_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] fib_index;
    logic [MOD_WIDTH-1:0]   modulus;

    modport source (output valid, output fib_index, output modulus, input ready);
    modport sink   (input valid, input fib_index, input modulus, output ready);
endinterface

interface fmfd_rsp_if
    import fmfd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] fib_residue;

    modport source (output valid, output fib_residue, input ready);
    modport sink   (input valid, input fib_residue, output ready);
endinterface

### sv/fibonacci_mod_fast_doubling.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_fast_doubling
// Computes F(n) mod p by fast doubling over the index bits, using one
// shift-add modular multiplier under a small sequencer.
//
//   channel  modport  payload                          handshake
//   req      sink     fib_index[IW], modulus[63]       valid/ready
//   rsp      source   fib_residue[63]                  valid/ready
//
// Each request walks every index bit with three modular products, each done
// in the multiplier as one shift-add step per multiplier bit.
// A zero modulus goes straight to the finish state with a zero residue.
// The request side is ready only while the sequencer is idle; the result
// waits in an output register, so a new request may start while it is held.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module fibonacci_mod_fast_doubling
    import fmfd_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    fmfd_req_if.sink   req,
    fmfd_rsp_if.source rsp
);

    localparam int BIT_W = $clog2(INDEX_WIDTH);

    state_t                 state_reg,   state_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [MUL_CNT_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [INDEX_WIDTH-1:0] n_reg, n_next;
    res_t                   p_reg, p_next;
    res_t                   a_reg, a_next;
    res_t                   b_reg, b_next;
    res_t                   c_reg, c_next;
    res_t                   m_reg, m_next;
    res_t                   acc_reg, acc_next;
    res_t                   mx_reg, mx_next;
    res_t                   my_reg, my_next;
    res_t                   res_reg, res_next;

    logic                   out_free;
    logic                   mul_last;
    res_t                   acc_dbl;
    res_t                   acc_step;

    // Shared multiplier step: double the accumulator, add x on a one bit.
    assign acc_dbl  = add_mod(acc_reg, acc_reg, p_reg);
    assign acc_step = my_reg[MOD_WIDTH-1] ? add_mod(acc_dbl, mx_reg, p_reg) : acc_dbl;
    assign mul_last = (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));

    assign out_free = !rsp_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.fib_residue = res_reg;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        rsp_valid_next = rsp.ready ? 1'b0 : rsp_valid_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    n_next       = req.fib_index;
                    p_next       = req.modulus;
                    a_next       = '0;
                    b_next       = (req.modulus == res_t'(1)) ? '0 : res_t'(1);
                    bit_cnt_next = BIT_W'(INDEX_WIDTH - 1);
                    state_next   = (req.modulus == '0) ? ST_FIN : ST_DBL;
                end
            end
            ST_DBL:
            begin
                c_next     = add_mod(b_reg, b_reg, p_reg);
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                // Load the multiplier with a * (2b - a).
                mx_next      = a_reg;
                my_next      = sub_mod(c_reg, a_reg, p_reg);
                acc_next     = '0;
                mul_cnt_next = '0;
                state_next   = ST_MUL_C;
            end
            ST_MUL_C, ST_MUL_AA, ST_MUL_BB:
            begin
                acc_next     = acc_step;
                my_next      = {my_reg[MOD_WIDTH-2:0], 1'b0};
                mul_cnt_next = mul_cnt_reg + MUL_CNT_W'(1);
                if (mul_last)
                begin
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    if (state_reg == ST_MUL_C)
                    begin
                        c_next     = acc_step;
                        mx_next    = a_reg;
                        my_next    = a_reg;
                        state_next = ST_MUL_AA;
                    end
                    else if (state_reg == ST_MUL_AA)
                    begin
                        m_next     = acc_step;
                        mx_next    = b_reg;
                        my_next    = b_reg;
                        state_next = ST_MUL_BB;
                    end
                    else
                    begin
                        m_next     = add_mod(m_reg, acc_step, p_reg);
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                // Keep (c, d) on a zero bit, advance to (d, c + d) on a one bit.
                if (n_reg[INDEX_WIDTH-1])
                begin
                    a_next = m_reg;
                    b_next = add_mod(c_reg, m_reg, p_reg);
                end
                else
                begin
                    a_next = c_reg;
                    b_next = m_reg;
                end
                n_next = {n_reg[INDEX_WIDTH-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                    state_next   = ST_DBL;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    res_next       = a_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        p_reg   <= p_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        res_reg <= res_next;
    end

    // A zero modulus skips the doubling walk entirely.
    a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.modulus == '0) |=> (state_reg == ST_FIN))
        else $error("zero modulus did not go straight to finish");

    // A delivered residue is reduced below the modulus.
    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (res_reg < p_reg || res_reg == '0))
        else $error("residue not reduced");

    // The multiplier counter runs only inside the product states.
    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_cnt_reg != '0) |->
            (state_reg == ST_MUL_C || state_reg == ST_MUL_AA || state_reg == ST_MUL_BB))
        else $error("multiplier counter active outside a product");

    // The pair stays reduced while the walk is in progress.
    a_pair_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_FIN) |-> (a_reg < p_reg && b_reg < p_reg))
        else $error("fast-doubling pair left its range");

endmodule

### tb/fibonacci_mod_fast_doubling_tb.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_fast_doubling_tb
// Self-checking testbench for the fast-doubling Fibonacci residue block.
// Requests go in over the valid/ready request channel. Each residue that
// comes back is compared with a value computed here from the same index and
// modulus. The run has directed corner cases, a long output stall that backs
// up the block, and a random phase with bursty requests and a stalling sink.
// ----------------------------------------------------------------------------
module fibonacci_mod_fast_doubling_tb
    import fmfd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDX_W            = INDEX_WIDTH_DEF;
    localparam int          RANDOM_REQUESTS  = 100;
    localparam int          LONG_HOLD_CYCLES = 30000;
    // Drain time covers one request at full index width.
    localparam int          DRAIN_CYCLES     = 12400;
    localparam longint      CYCLE_LIMIT      = 10_000_000;
    localparam int          MAX_REPORTS      = 10;

    typedef logic [IDX_W-1:0] index_t;

    typedef struct {
        index_t fib_index;
        res_t   modulus;
        res_t   fib_residue;
    } residue_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    fmfd_req_if #(.INDEX_WIDTH(IDX_W)) req_ch ();
    fmfd_rsp_if                        rsp_ch ();

    residue_expect_t pending_residues[$];
    int unsigned     mismatch_count = 0;
    longint          cycle_count    = 0;
    bit              gaps_enabled   = 1'b1;
    int unsigned     burst_left     = 1;
    logic            hold_toggle    = 1'b0;

    fibonacci_mod_fast_doubling #(
        .INDEX_WIDTH (IDX_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Residue arithmetic for the expected values
    // ------------------------------------------------------------------------

    // Sum of two residues below p, reduced once.
    function automatic res_t residue_add(input res_t x, input res_t y, input res_t p);
        logic [MOD_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[MOD_WIDTH-1:0];
    endfunction

    // Difference of two residues below p, wrapped into range.
    function automatic res_t residue_sub(input res_t x, input res_t y, input res_t p);
        if (x >= y)
            return x - y;
        return x + (p - y);
    endfunction

    // Product by double-and-add, most significant multiplier bit first.
    function automatic res_t residue_mul(input res_t x, input res_t y, input res_t p);
        res_t r;
        r = '0;
        for (int i = MOD_WIDTH - 1; i >= 0; i--)
        begin
            r = residue_add(r, r, p);
            if (y[i])
                r = residue_add(r, x, p);
        end
        return r;
    endfunction

    // F(n) mod p by fast doubling over every index bit, top bit first.
    // Leading zero bits keep the pair at (0, 1), so no bit search is needed.
    function automatic res_t fib_residue_of(input index_t n, input res_t p);
        res_t fa;
        res_t fb;
        res_t c;
        res_t d;
        if (p == '0)
            return '0;
        fa = '0;
        fb = (p == res_t'(1)) ? res_t'(0) : res_t'(1);
        for (int i = IDX_W - 1; i >= 0; i--)
        begin
            c = residue_mul(fa, residue_sub(residue_add(fb, fb, p), fa, p), p);
            d = residue_add(residue_mul(fa, fa, p), residue_mul(fb, fb, p), p);
            if (n[i])
            begin
                fa = d;
                fb = residue_add(c, d, p);
            end
            else
            begin
                fa = c;
                fb = d;
            end
        end
        return fa;
    endfunction

    // ------------------------------------------------------------------------
    // Random field values
    // ------------------------------------------------------------------------

    function automatic index_t random_index();
        return index_t'({$urandom, $urandom});
    endfunction

    function automatic res_t random_modulus();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MOD_WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: holds one request until it is taken, then either keeps
    // valid high for the next one or ends the burst with an idle gap.
    // ------------------------------------------------------------------------
    task automatic send_request(input index_t n, input res_t p);
        residue_expect_t e;
        int unsigned gap;
        req_ch.valid     <= 1'b1;
        req_ch.fib_index <= n;
        req_ch.modulus   <= p;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        e.fib_index   = n;
        e.modulus     = p;
        e.fib_residue = fib_residue_of(n, p);
        pending_residues.push_back(e);
        if (gaps_enabled)
        begin
            burst_left--;
            if (burst_left == 0)
            begin
                // Mostly short gaps; some long enough to land mid-computation.
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3000)
                                                  : $urandom_range(1, 16);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 6);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: a rotating ready mask that is replaced now and then, with
    // some stretches fully ready. A toggle from the test starts a long hold.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        int unsigned mask_age;
        logic [15:0] ready_mask;
        logic        seen_toggle;
        hold_left   = 0;
        mask_age    = 0;
        ready_mask  = '1;
        seen_toggle = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mask_age == 0)
                begin
                    mask_age   = $urandom_range(64, 512);
                    ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                             : 16'($urandom) | 16'h0001;
                end
                mask_age--;
                rsp_ch.ready <= ready_mask[0];
                ready_mask = {ready_mask[0], ready_mask[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Residue checker: every taken result is matched with the oldest request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        residue_expect_t e;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_residues.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: fib_residue %0d",
                             $realtime, rsp_ch.fib_residue);
            end
            else
            begin
                e = pending_residues.pop_front();
                if (rsp_ch.fib_residue !== e.fib_residue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] mismatch n=%0d p=%0d: fib_residue expected %0d got %0d",
                                 $realtime, e.fib_index, e.modulus, e.fib_residue,
                                 rsp_ch.fib_residue);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and known values, including the largest F(n) that fits.
    task automatic test_field_extremes();
        res_t p_max;
        p_max = '1;
        send_request(index_t'(1), p_max);
        send_request(index_t'(2), p_max);
        send_request(index_t'(3), p_max);
        send_request(index_t'(92), p_max);
        send_request(index_t'(93), p_max);
        send_request('1, p_max);
        send_request(index_t'(1) << (IDX_W - 1), p_max);
        send_request(index_t'(64'h5555_5555_5555_5555), res_t'(1) << (MOD_WIDTH - 1));
        send_request(index_t'(64'hAAAA_AAAA_AAAA_AAAA), res_t'(63'h2AAA_AAAA_AAAA_AAAA));
        send_request('1, res_t'(2));
        send_request(index_t'(1000), res_t'(1_000_000_007));
    endtask

    // Zero index, unit modulus and zero modulus all give a zero residue.
    task automatic test_zero_cases();
        send_request('0, '1);
        send_request('0, res_t'(7));
        send_request(random_index(), res_t'(1));
        send_request('1, res_t'(1));
        send_request(random_index(), '0);
        send_request('0, '0);
        send_request('1, '0);
    endtask

    // Hold the result side for a long time while requests keep coming, so
    // the output register fills and the request side has to stall.
    task automatic test_output_backpressure();
        gaps_enabled = 1'b0;
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 4; i++)
            send_request(random_index(), random_modulus());
        gaps_enabled = 1'b1;
        burst_left   = 1;
    endtask

    // Random requests with a mix of modulus sizes and index lengths.
    task automatic test_random_requests();
        index_t n;
        res_t   p;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            case ($urandom_range(0, 9))
                0:       p = res_t'($urandom_range(0, 1));
                1, 2:    p = res_t'($urandom_range(2, 1000));
                3:       p = res_t'(1) << $urandom_range(1, MOD_WIDTH - 1);
                default: p = random_modulus();
            endcase
            case ($urandom_range(0, 4))
                0:       n = index_t'($urandom_range(0, 300));
                1:       n = random_index() >> $urandom_range(0, IDX_W - 1);
                default: n = random_index();
            endcase
            send_request(n, p);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.fib_index <= '0;
        req_ch.modulus   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_zero_cases();
        test_output_backpressure();
        test_random_requests();

        req_ch.valid <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
